FILE: design/acr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, constants and arithmetic step functions for the
// rectangle-versus-shape collision resolver.
// ----------------------------------------------------------------------------
package acr_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 2'd3;

	// 0.0001 in Q16.16, rounded
	localparam int EPS_LSB = 7;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 18;

	typedef struct packed {
		logic               shape_kind;
		logic signed [31:0] other_left;
		logic signed [31:0] other_bottom;
		logic signed [31:0] other_right;
		logic signed [31:0] other_top;
		logic signed [31:0] circle_x;
		logic signed [31:0] circle_y;
		logic        [30:0] circle_radius;
	} in_item_t;

	typedef struct packed {
		logic               collides;
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
	} out_item_t;

	// classified request, front end to back end
	typedef struct packed {
		logic               corner;
		logic               boxpass;
		logic               near_ok;
		logic               dxneg;
		logic               dyneg;
		logic               sh;
		logic        [30:0] rad;
		logic        [31:0] ax;
		logic        [31:0] ay;
		logic        [31:0] hx;
		logic        [31:0] hy;
		logic signed [35:0] px;
		logic signed [35:0] py;
	} job_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [47:0] rem;
		logic [17:0] q;
	} dv_t;

	function automatic logic signed [35:0] mag36(input logic signed [35:0] v);
		return v[35] ? -v : v;
	endfunction

	function automatic logic signed [33:0] mag34(input logic signed [33:0] v);
		return v[33] ? -v : v;
	endfunction

	// one result bit of a restoring square root
	function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
		logic [34:0] acc;
		logic [34:0] trial;
		sq_t         o;
		acc   = {s.rem[32:0], pair};
		trial = {1'b0, s.root, 2'b01};
		if (acc >= trial) begin
			o.rem  = acc - trial;
			o.root = {s.root[30:0], 1'b1};
		end else begin
			o.rem  = acc;
			o.root = {s.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of a restoring divide, bit position j
	function automatic dv_t div_step(input dv_t s, input logic [32:0] dvsr, input int j);
		logic [50:0] dsh;
		dv_t         o;
		dsh = 51'(dvsr) << j;
		o   = s;
		if ({3'b000, s.rem} >= dsh) begin
			o.rem = s.rem - dsh[47:0];
			o.q   = s.q | (18'(1) << j);
		end
		return o;
	endfunction

	function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
		if (v > 38'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -38'sd2147483648)
			return 32'sh80000000;
		else
			return signed'(v[31:0]);
	endfunction

endpackage
`default_nettype wire

FILE: design/aabb_circle_collision_resolve_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_circle_collision_resolve_core
// Box or circle against a configured rectangle: overlap flag and push vector.
// ----------------------------------------------------------------------------
// One request is taken every cycle that start is high and busy is low. Each
// result appears on rsp with done high for exactly one cycle; the path runs
// through the 32-step square root and the 18-step dividers of the corner push.
// Results leave in request order. The back end drains the queue every cycle,
// so busy stays low in normal use. The user must write rectangle registers
// through cfg_we/cfg_idx/cfg_wdata only while no request is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module aabb_circle_collision_resolve_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  acr_pkg::in_item_t                 req,
	output logic                              done,
	output acr_pkg::out_item_t                rsp,
	input  logic                              cfg_we,
	input  logic [acr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [31:0]                       cfg_wdata
);

	logic signed [31:0] rect_left_q, rect_bottom_q, rect_right_q, rect_top_q;
	acr_pkg::job_t      fe_job, q_job;
	logic               q_full, q_valid, accept;

	assign busy   = q_full;
	assign accept = start & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_bottom_q <= '0;
			rect_right_q  <= '0;
			rect_top_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				acr_pkg::REG_RECT_LEFT:   rect_left_q   <= signed'(cfg_wdata);
				acr_pkg::REG_RECT_BOTTOM: rect_bottom_q <= signed'(cfg_wdata);
				acr_pkg::REG_RECT_RIGHT:  rect_right_q  <= signed'(cfg_wdata);
				acr_pkg::REG_RECT_TOP:    rect_top_q    <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	acr_front u_front (
		.item        (req),
		.rect_left   (rect_left_q),
		.rect_bottom (rect_bottom_q),
		.rect_right  (rect_right_q),
		.rect_top    (rect_top_q),
		.job         (fe_job)
	);

	acr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (fe_job),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_job)
	);

	acr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job_v  (q_valid),
		.job    (q_job),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

FILE: design/acr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acr_front
// Classifies one request: box test, strip test, axis push and the corner
// distance terms handed to the back end.
// ----------------------------------------------------------------------------
module acr_front (
	input  acr_pkg::in_item_t  item,
	input  logic signed [31:0] rect_left,
	input  logic signed [31:0] rect_bottom,
	input  logic signed [31:0] rect_right,
	input  logic signed [31:0] rect_top,
	output acr_pkg::job_t      job
);

	logic signed [33:0] cx, cy, rad_w, l, b, r, t, rl, rb, rr, rt, eps;
	logic signed [33:0] dlx, drx, dby, dty, dx, dy, adx, ady;
	logic signed [35:0] x0, xa, xs, y0, ya, ys;
	logic               strip;
	logic        [31:0] ax, ay;
	logic               sh;

	assign cx    = 34'(item.circle_x);
	assign cy    = 34'(item.circle_y);
	assign rad_w = signed'({3'b000, item.circle_radius});
	assign rl    = 34'(rect_left);
	assign rb    = 34'(rect_bottom);
	assign rr    = 34'(rect_right);
	assign rt    = 34'(rect_top);
	assign eps   = 34'(acr_pkg::EPS_LSB);

	assign l = item.shape_kind ? cx - rad_w : 34'(item.other_left);
	assign b = item.shape_kind ? cy - rad_w : 34'(item.other_bottom);
	assign r = item.shape_kind ? cx + rad_w : 34'(item.other_right);
	assign t = item.shape_kind ? cy + rad_w : 34'(item.other_top);

	// smaller signed overlap per axis, then keep only one axis
	assign x0 = 36'(rr) - 36'(l);
	assign xa = 36'(rl) - 36'(r);
	assign xs = (acr_pkg::mag36(xa) < x0) ? xa : x0;
	assign y0 = 36'(rb) - 36'(t);
	assign ya = 36'(rt) - 36'(b);
	assign ys = (ya < acr_pkg::mag36(y0)) ? ya : y0;

	assign strip = (cx > rl - eps && cx < rr + eps) || (cy > rb - eps && cy < rt + eps);

	// nearest corner, max border on a tie
	assign dlx = cx - rl;
	assign drx = cx - rr;
	assign dby = cy - rb;
	assign dty = cy - rt;
	assign dx  = (acr_pkg::mag34(dlx) < acr_pkg::mag34(drx)) ? dlx : drx;
	assign dy  = (acr_pkg::mag34(dby) < acr_pkg::mag34(dty)) ? dby : dty;
	assign adx = acr_pkg::mag34(dx);
	assign ady = acr_pkg::mag34(dy);
	assign ax  = adx[31:0];
	assign ay  = ady[31:0];
	assign sh  = ax[31] | ay[31];

	always_comb begin
		job.corner  = item.shape_kind & ~strip;
		job.boxpass = !(r < rl || l > rr || t < rb || b > rt);
		job.near_ok = (ax < {1'b0, item.circle_radius}) && (ay < {1'b0, item.circle_radius});
		job.dxneg   = dx[33];
		job.dyneg   = dy[33];
		job.sh      = sh;
		job.rad     = item.circle_radius;
		job.ax      = ax;
		job.ay      = ay;
		job.hx      = sh ? {1'b0, ax[31:1]} : ax;
		job.hy      = sh ? {1'b0, ay[31:1]} : ay;
		if (acr_pkg::mag36(ys) > acr_pkg::mag36(xs)) begin
			job.px = xs;
			job.py = '0;
		end else begin
			job.px = '0;
			job.py = ys;
		end
	end

endmodule
`default_nettype wire

FILE: design/acr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acr_queue
// Short request queue between the classifier and the arithmetic back end.
// ----------------------------------------------------------------------------
module acr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  acr_pkg::job_t wdata,
	output logic          full,
	output logic          valid,
	output acr_pkg::job_t rdata
);

	acr_pkg::job_t                     mem_q [acr_pkg::QDEPTH];
	logic [acr_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [acr_pkg::QCNT_W-1:0]        cnt_q;
	logic                              pop;

	// back end never stalls: drain whenever something is queued
	assign pop   = cnt_q != '0;
	assign valid = pop;
	assign rdata = mem_q[rd_ptr_q];
	assign full  = cnt_q == acr_pkg::QCNT_W'(acr_pkg::QDEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + acr_pkg::QCNT_W'(push) - acr_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

FILE: design/acr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acr_back
// Pipelined corner push: squares, 32-step square root, two 18-step
// dividers, scale multiply, then result select and saturation.
// ----------------------------------------------------------------------------
module acr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_v,
	input  acr_pkg::job_t      job,
	output logic               done,
	output acr_pkg::out_item_t rsp
);

	localparam int SQN = acr_pkg::SQ_STEPS;
	localparam int DVN = acr_pkg::DIV_STEPS;

	logic          v_s1, v_s2;
	acr_pkg::job_t job_s1, job_s2;
	logic [63:0]   hxx_s2, hyy_s2, rr_s2;
	logic [63:0]   nsum;

	logic          sq_v_s   [SQN+1];
	acr_pkg::job_t sq_job_s [SQN+1];
	logic          sq_hit_s [SQN+1];
	logic [63:0]   sq_n_s   [SQN+1];
	acr_pkg::sq_t  sq_st_s  [SQN+1];

	logic               [32:0] dist_w;
	logic signed        [34:0] diff_w, adiff_w;

	logic          dv_v_s     [DVN+1];
	acr_pkg::job_t dv_job_s   [DVN+1];
	logic          dv_hit_s   [DVN+1];
	logic [32:0]   dv_dist_s  [DVN+1];
	logic [33:0]   dv_adiff_s [DVN+1];
	logic          dv_dneg_s  [DVN+1];
	acr_pkg::dv_t  dv_x_s     [DVN+1];
	acr_pkg::dv_t  dv_y_s     [DVN+1];

	logic          mul_v_s5;
	acr_pkg::job_t mul_job_s5;
	logic          mul_hit_s5, mul_dz_s5, mul_dneg_s5;
	logic [51:0]   prod_x_s5, prod_y_s5;

	logic signed [37:0] mx, my, cx_w, cy_w, fx, fy;
	logic               done_q;
	acr_pkg::out_item_t rsp_q;

	assign nsum = hxx_s2 + hyy_s2;

	assign dist_w  = sq_job_s[SQN].sh ? {sq_st_s[SQN].root, 1'b0} : {1'b0, sq_st_s[SQN].root};
	assign diff_w  = signed'({4'b0000, sq_job_s[SQN].rad}) - signed'({2'b00, dist_w});
	assign adiff_w = diff_w[34] ? -diff_w : diff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			mul_v_s5 <= 1'b0;
			done_q   <= 1'b0;
			for (int k = 0; k <= SQN; k++)
				sq_v_s[k] <= 1'b0;
			for (int k = 0; k <= DVN; k++)
				dv_v_s[k] <= 1'b0;
		end else begin
			v_s1      <= job_v;
			v_s2      <= v_s1;
			sq_v_s[0] <= v_s2;
			for (int k = 0; k < SQN; k++)
				sq_v_s[k+1] <= sq_v_s[k];
			dv_v_s[0] <= sq_v_s[SQN];
			for (int k = 0; k < DVN; k++)
				dv_v_s[k+1] <= dv_v_s[k];
			mul_v_s5 <= dv_v_s[DVN];
			done_q   <= mul_v_s5;
		end
	end

	always_ff @(posedge clk) begin
		job_s1 <= job;
		job_s2 <= job_s1;
		hxx_s2 <= job_s1.hx * job_s1.hx;
		hyy_s2 <= job_s1.hy * job_s1.hy;
		rr_s2  <= job_s1.rad * job_s1.rad;

		// corner hit only counts when both offsets are under the radius
		sq_job_s[0] <= job_s2;
		sq_n_s[0]   <= nsum;
		sq_st_s[0]  <= '0;
		sq_hit_s[0] <= job_s2.corner ?
			(job_s2.boxpass && job_s2.near_ok && (nsum < rr_s2)) : job_s2.boxpass;
		for (int k = 0; k < SQN; k++) begin
			sq_job_s[k+1] <= sq_job_s[k];
			sq_n_s[k+1]   <= sq_n_s[k];
			sq_hit_s[k+1] <= sq_hit_s[k];
			sq_st_s[k+1]  <= acr_pkg::sqrt_step(sq_st_s[k], sq_n_s[k][63-2*k -: 2]);
		end

		dv_job_s[0]   <= sq_job_s[SQN];
		dv_hit_s[0]   <= sq_hit_s[SQN];
		dv_dist_s[0]  <= dist_w;
		dv_adiff_s[0] <= adiff_w[33:0];
		dv_dneg_s[0]  <= diff_w[34];
		dv_x_s[0]     <= {sq_job_s[SQN].ax, 16'd0, 18'd0};
		dv_y_s[0]     <= {sq_job_s[SQN].ay, 16'd0, 18'd0};
		for (int k = 0; k < DVN; k++) begin
			dv_job_s[k+1]   <= dv_job_s[k];
			dv_hit_s[k+1]   <= dv_hit_s[k];
			dv_dist_s[k+1]  <= dv_dist_s[k];
			dv_adiff_s[k+1] <= dv_adiff_s[k];
			dv_dneg_s[k+1]  <= dv_dneg_s[k];
			dv_x_s[k+1]     <= acr_pkg::div_step(dv_x_s[k], dv_dist_s[k], DVN-1-k);
			dv_y_s[k+1]     <= acr_pkg::div_step(dv_y_s[k], dv_dist_s[k], DVN-1-k);
		end

		mul_job_s5  <= dv_job_s[DVN];
		mul_hit_s5  <= dv_hit_s[DVN];
		mul_dz_s5   <= dv_dist_s[DVN] == '0;
		mul_dneg_s5 <= dv_dneg_s[DVN];
		prod_x_s5   <= dv_x_s[DVN].q * dv_adiff_s[DVN];
		prod_y_s5   <= dv_y_s[DVN].q * dv_adiff_s[DVN];

		rsp_q.collides <= mul_hit_s5;
		rsp_q.push_x   <= acr_pkg::sat38(fx);
		rsp_q.push_y   <= acr_pkg::sat38(fy);
	end

	always_comb begin
		mx   = signed'({2'b00, prod_x_s5[51:16]});
		my   = signed'({2'b00, prod_y_s5[51:16]});
		cx_w = mul_dz_s5 ? '0 : ((mul_job_s5.dxneg != mul_dneg_s5) ? -mx : mx);
		cy_w = mul_dz_s5 ? '0 : ((mul_job_s5.dyneg != mul_dneg_s5) ? -my : my);
		fx   = mul_job_s5.corner ? cx_w : 38'(mul_job_s5.px);
		fy   = mul_job_s5.corner ? cy_w : 38'(mul_job_s5.py);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_follows_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(mul_v_s5))
		else $error("result strobe without a multiply stage entry");

	a_hit_needs_box: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v_s[0] && sq_hit_s[0]) |-> sq_job_s[0].boxpass)
		else $error("hit flagged for a request that fails the box test");

	a_mul_follows_div: assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s5 |-> $past(dv_v_s[DVN]))
		else $error("multiply stage entry without a divider output");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives box and circle requests against several rectangle settings and
// checks each overlap flag and push vector against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class collision_board;
		logic signed [63:0] r_left, r_bottom, r_right, r_top;
		acr_pkg::out_item_t pending[$];
		int mismatches;

		function new();
			r_left = 0; r_bottom = 0; r_right = 0; r_top = 0;
			mismatches = 0;
		endfunction

		function void set_rect(logic [1:0] idx, logic [31:0] val);
			logic signed [63:0] v;
			v = 64'(signed'(val));
			case (idx)
				acr_pkg::REG_RECT_LEFT: r_left = v;
				acr_pkg::REG_RECT_BOTTOM: r_bottom = v;
				acr_pkg::REG_RECT_RIGHT: r_right = v;
				acr_pkg::REG_RECT_TOP: r_top = v;
				default: ;
			endcase
		endfunction

		function logic signed [63:0] absv(logic signed [63:0] v);
			return v < 0 ? -v : v;
		endfunction

		function logic [63:0] root64(logic [63:0] n);
			logic [63:0] rt, b;
			rt = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= rt + b) begin
					n = n - (rt + b);
					rt = (rt >> 1) + b;
				end else begin
					rt = rt >> 1;
				end
				b = b >> 2;
			end
			return rt;
		endfunction

		function logic signed [31:0] clamp32(logic signed [63:0] v);
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void box_push(logic signed [63:0] l, b, r, t,
				output logic signed [63:0] px, output logic signed [63:0] py);
			logic signed [63:0] alt;
			px = r_right - l;
			py = r_bottom - t;
			alt = r_left - r;
			if (absv(alt) < px) px = alt;
			alt = r_top - b;
			if (alt < absv(py)) py = alt;
			if (absv(py) > absv(px)) py = 0;
			else px = 0;
		endfunction

		function logic signed [63:0] corner_push(logic signed [63:0] d, logic [63:0] cdist,
				logic signed [63:0] diff);
			logic [63:0] u, m;
			u = (64'(absv(d)) << 16) / cdist;
			m = (u * 64'(absv(diff))) >> 16;
			return ((d < 0) != (diff < 0)) ? -$signed(m) : $signed(m);
		endfunction

		function void note_request(acr_pkg::in_item_t it);
			logic signed [63:0] l, b, r, t, px, py, cx, cy, rad, kx, ky, dx, dy;
			logic [63:0] ax, ay, hx, hy, cdist;
			logic hit, strip;
			int sh;
			acr_pkg::out_item_t o;
			px = 0; py = 0;
			if (!it.shape_kind) begin
				l = it.other_left; b = it.other_bottom;
				r = it.other_right; t = it.other_top;
				hit = !(r < r_left || l > r_right || t < r_bottom || b > r_top);
				box_push(l, b, r, t, px, py);
			end else begin
				cx = it.circle_x; cy = it.circle_y;
				rad = {33'd0, it.circle_radius};
				l = cx - rad; b = cy - rad; r = cx + rad; t = cy + rad;
				strip = (cx > r_left - acr_pkg::EPS_LSB && cx < r_right + acr_pkg::EPS_LSB) ||
					(cy > r_bottom - acr_pkg::EPS_LSB && cy < r_top + acr_pkg::EPS_LSB);
				kx = (absv(cx - r_left) < absv(cx - r_right)) ? r_left : r_right;
				ky = (absv(cy - r_bottom) < absv(cy - r_top)) ? r_bottom : r_top;
				dx = cx - kx; dy = cy - ky;
				ax = absv(dx); ay = absv(dy);
				if (strip) begin
					box_push(l, b, r, t, px, py);
				end else begin
					sh = (ax >= 64'h80000000 || ay >= 64'h80000000) ? 1 : 0;
					hx = ax >> sh; hy = ay >> sh;
					cdist = root64(hx * hx + hy * hy) << sh;
					if (cdist != 0) begin
						px = corner_push(dx, cdist, rad - $signed(cdist));
						py = corner_push(dy, cdist, rad - $signed(cdist));
					end
				end
				if (r < r_left || l > r_right || t < r_bottom || b > r_top) hit = 0;
				else if (strip) hit = 1;
				else hit = ax < rad && ay < rad && (ax * ax + ay * ay) < rad * rad;
			end
			o.collides = hit;
			o.push_x = clamp32(px);
			o.push_y = clamp32(py);
			pending.push_back(o);
		endfunction

		function logic check_result(acr_pkg::out_item_t got);
			acr_pkg::out_item_t w;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return 1;
			end
			w = pending.pop_front();
			if (got.collides !== w.collides || got.push_x !== w.push_x ||
					got.push_y !== w.push_y) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: want %p got %p", w, got);
				return 1;
			end
			return 0;
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, cfg_we;
	acr_pkg::in_item_t req;
	acr_pkg::out_item_t rsp;
	logic [acr_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_wdata;
	collision_board board;
	longint cycles;
	int err_count;

	aabb_circle_collision_resolve_core dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) err_count <= err_count + int'(board.check_result(rsp));
		if (cycles > 400000) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_rect(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
		board.set_rect(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_rect_all(logic [31:0] l, b, r, t);
		write_rect(acr_pkg::REG_RECT_LEFT, l);
		write_rect(acr_pkg::REG_RECT_BOTTOM, b);
		write_rect(acr_pkg::REG_RECT_RIGHT, r);
		write_rect(acr_pkg::REG_RECT_TOP, t);
	endtask

	// hold start for one request; returns with start still high
	task automatic send_request(acr_pkg::in_item_t it);
		start <= 1;
		req <= it;
		do @(posedge clk); while (busy);
		board.note_request(it);
	endtask

	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(int span);
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom;
			default: return $signed($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic acr_pkg::in_item_t random_item(int span);
		acr_pkg::in_item_t it;
		logic signed [31:0] c;
		it.shape_kind = 1'($urandom_range(0, 1));
		c = pick_coord(span);
		it.other_left = c;
		it.other_right = ($urandom_range(0, 7) == 0) ? pick_coord(span)
			: c + $signed($urandom_range(0, span));
		c = pick_coord(span);
		it.other_bottom = c;
		it.other_top = ($urandom_range(0, 7) == 0) ? pick_coord(span)
			: c + $signed($urandom_range(0, span));
		it.circle_x = pick_coord(span);
		it.circle_y = pick_coord(span);
		case ($urandom_range(0, 5))
			0: it.circle_radius = 31'($urandom);
			1: it.circle_radius = 0;
			default: it.circle_radius = 31'($urandom_range(0, span));
		endcase
		return it;
	endfunction

	initial begin
		acr_pkg::in_item_t it;
		int span, burst;
		board = new();
		cycles = 0; err_count = 0;
		start = 0; req = '0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// directed: reset rectangle first, then a box from -1.0 to 1.0 on each axis
		it = '0;
		send_request(it);
		drain();
		set_rect_all(32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 32'h00010000);
		it = '0;
		it.other_left = 32'h80000000; it.other_bottom = 32'h80000000;
		it.other_right = 32'h7FFFFFFF; it.other_top = 32'h7FFFFFFF;
		send_request(it);
		it.other_left = 32'h00010000; it.other_right = 32'h00020000;
		it.other_bottom = 0; it.other_top = 32'h00000100;
		send_request(it); // touching border
		it.other_left = 32'h00010001;
		send_request(it);
		it = '0; it.shape_kind = 1;
		it.circle_radius = 31'h7FFFFFFF;
		send_request(it);
		it.circle_x = 32'h00010000 + 6; it.circle_y = 32'h00030000;
		it.circle_radius = 31'h00020000;
		send_request(it); // inside margin strip
		it.circle_x = 32'h00010000 + 7;
		send_request(it); // just past margin: corner case
		it.circle_x = 32'h00010000; it.circle_y = 32'h00010000;
		send_request(it);
		it.circle_x = 32'h00020000; it.circle_y = 32'h00020000;
		it.circle_radius = 31'h00010000;
		send_request(it); // radius below corner distance
		it.circle_x = 32'h7FFFFFFF; it.circle_y = 32'h80000000;
		it.circle_radius = 31'h7FFFFFFF;
		send_request(it); // huge corner distance
		it.circle_x = 32'h80000000; it.circle_y = 32'h7FFFFFFF;
		it.circle_radius = 0;
		send_request(it);
		drain();
		// zero corner distance: circle right on a corner of a degenerate rect
		set_rect_all(32'h00050000, 32'h00050000, 32'h00040000, 32'h00040000);
		it = '0; it.shape_kind = 1;
		it.circle_x = 32'h00050000; it.circle_y = 32'h00050000;
		it.circle_radius = 31'h00001000;
		send_request(it);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_rect_all(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
				1: set_rect_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
				2: set_rect_all(0, 0, 0, 0);
				default: set_rect_all($urandom_range(0, 32'h80000) - 32'h40000,
					$urandom_range(0, 32'h80000) - 32'h40000,
					$urandom_range(0, 32'h80000), $urandom_range(0, 32'h80000));
			endcase
			span = (phase < 3) ? 32'h40000 : 32'h100000;
			for (int n = 0; n < 250; ) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst && n < 250; k++, n++)
					send_request(random_item(span));
				if ($urandom_range(0, 2) != 0) begin
					start <= 0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			drain();
		end

		if (board.pending.size() == 0 && err_count == 0 && board.mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
